// File: rtl/core/hbs_pkg.sv
// Shared constants and types for the heightmap bilinear sampler.
package hbs_pkg;

  localparam int GRID_MAX_DEF = 32;
  localparam int HB           = 16;

  localparam int RES_W   = 6;
  localparam int HALF_W  = 15;
  localparam int SCALE_W = 24;
  localparam int POS_W   = 16;
  localparam int COORD_W = 6;
  localparam int CFG_W   = 24;

  localparam logic [RES_W-1:0]   RES_RST   = 6'd16;
  localparam logic [HALF_W-1:0]  HALF_RST  = 15'd5120;
  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd26214;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    CFG_GRID_RES   = 3'd0,
    CFG_HALF_WIDTH = 3'd1,
    CFG_HALF_DEPTH = 3'd2,
    CFG_SCALE_X    = 3'd3,
    CFG_SCALE_Z    = 3'd4
  } cfg_index_t;

  localparam int SUM_W  = POS_W + 1;
  localparam int FX_W   = SUM_W + SCALE_W + 1;
  localparam int FRAC_B = 24;
  localparam int FL_W   = FX_W - FRAC_B;
  localparam int T_LO   = 21;
  localparam int T_HI_W = FX_W - T_LO;
  localparam int D_W    = HB + 1;
  localparam int PL_W   = T_LO + 1 + D_W;
  localparam int PH_W   = T_HI_W + D_W;
  localparam int A_W    = 60;
  localparam int E_W    = A_W + 1;
  localparam int E_LO   = 30;
  localparam int E_HI_W = E_W - E_LO;
  localparam int QLL_W  = T_LO + 1 + E_LO + 1;
  localparam int QHL_W  = T_HI_W + E_LO + 1;
  localparam int QLH_W  = T_LO + 1 + E_HI_W;
  localparam int QHH_W  = T_HI_W + E_HI_W;
  localparam int R_W    = 104;
  localparam int R_SH   = 48;
  localparam int Q_W    = R_W - R_SH;

  localparam logic signed [R_W-1:0] ROUND_HALF = R_W'(1) << (R_SH - 1);
  localparam logic signed [HB-1:0]  H_MAX      = {1'b0, {(HB-1){1'b1}}};
  localparam logic signed [HB-1:0]  H_MIN      = {1'b1, {(HB-1){1'b0}}};

endpackage

// File: rtl/core/heightmap_bilinear_sampler_core.sv
// Pipelined bilinear height sampler over a banked grid of Q8.8 heights.
//
// Channels: in (command, grid_col, grid_row, height_value, pos_x, pos_z) with
// in_valid/in_ready, out (sampled_height, saturated) with out_valid/out_ready,
// and a configuration write channel cfg_valid/cfg_ready/cfg_index/cfg_data that
// is always ready. A write command stores one height and yields no result; a
// sample command yields one result.
// A sample passes through every stage register and then the output register.
// Throughput: one item per cycle while the receiver takes results. The grid
// sits in four banks split by row and column parity, so the four corners of a
// cell are read in the same cycle, one port per bank; writes use the same
// memory stage, which keeps all items in order.
// Reset clears the pipeline and loads the default configuration. The height
// store is not cleared: write every entry a sample can touch first.
// When the receiver stalls, the output register holds and each stage holds
// only if the one after it is full, so empty stages keep taking transfers
// until the pipeline is full.
module heightmap_bilinear_sampler_core
  import hbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     command,
  input  logic [COORD_W-1:0]       grid_col,
  input  logic [COORD_W-1:0]       grid_row,
  input  logic signed [HB-1:0]     height_value,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [HB-1:0]     sampled_height,
  output logic                     saturated
);

  localparam int GRID_MAX   = GRID_MAX_DEF;
  localparam int IDX_W      = $clog2(GRID_MAX + 1);
  localparam int BANK_SIDE  = GRID_MAX / 2 + 1;
  localparam int BANK_DEPTH = BANK_SIDE * BANK_SIDE;
  localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  function automatic logic [IDX_W-1:0] cell_index(input logic signed [FL_W-1:0] fl,
                                                  input logic [IDX_W-1:0] lim);
    logic [IDX_W-1:0] r;
    if (fl < 0) begin
      r = '0;
    end else if (fl > $signed({1'b0, lim})) begin
      r = lim;
    end else begin
      r = IDX_W'(fl);
    end
    return r;
  endfunction

  function automatic logic [BA_W-1:0] bank_addr(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return BA_W'(r * BANK_SIDE + c);
  endfunction

  logic [RES_W-1:0]   grid_res;
  logic [HALF_W-1:0]  half_width;
  logic [HALF_W-1:0]  half_depth;
  logic [SCALE_W-1:0] scale_x;
  logic [SCALE_W-1:0] scale_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_res   <= RES_RST;
      half_width <= HALF_RST;
      half_depth <= HALF_RST;
      scale_x    <= SCALE_RST;
      scale_z    <= SCALE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRID_RES:   grid_res   <= cfg_data[RES_W-1:0];
        CFG_HALF_WIDTH: half_width <= cfg_data[HALF_W-1:0];
        CFG_HALF_DEPTH: half_depth <= cfg_data[HALF_W-1:0];
        CFG_SCALE_X:    scale_x    <= cfg_data[SCALE_W-1:0];
        CFG_SCALE_Z:    scale_z    <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [10:1] v;
  logic [11:1] rdy;

  always_comb begin
    rdy[11] = !out_valid || out_ready;
    for (int k = 10; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[1];

  // stage 1: offsets
  logic                     cmd_s1;
  logic [COORD_W-1:0]       col_s1, row_s1;
  logic signed [HB-1:0]     hval_s1;
  logic signed [SUM_W-1:0]  sum_x_s1, sum_z_s1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      cmd_s1   <= command;
      col_s1   <= grid_col;
      row_s1   <= grid_row;
      hval_s1  <= height_value;
      sum_x_s1 <= $signed({pos_x[POS_W-1], pos_x}) + $signed({2'b00, half_width});
      sum_z_s1 <= $signed({pos_z[POS_W-1], pos_z}) + $signed({2'b00, half_depth});
    end
  end

  // stage 2: scale, write address
  logic                     cmd_s2, wok_s2;
  logic [1:0]               wbank_s2;
  logic [BA_W-1:0]          waddr_s2;
  logic signed [HB-1:0]     hval_s2;
  logic signed [FX_W-1:0]   fx_s2, fz_s2;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      cmd_s2   <= cmd_s1;
      wok_s2   <= (int'(col_s1) <= GRID_MAX) && (int'(row_s1) <= GRID_MAX);
      wbank_s2 <= {row_s1[0], col_s1[0]};
      waddr_s2 <= bank_addr(IDX_W'(row_s1 >> 1), IDX_W'(col_s1 >> 1));
      hval_s2  <= hval_s1;
      fx_s2    <= sum_x_s1 * $signed({1'b0, scale_x});
      fz_s2    <= sum_z_s1 * $signed({1'b0, scale_z});
    end
  end

  // stage 3: cell index, fraction, bank addresses
  logic [IDX_W-1:0]         res_m1, ix_next, iz_next;
  logic [IDX_W-1:0]         brow_next [2];
  logic [IDX_W-1:0]         bcol_next [2];
  logic [3:0][BA_W-1:0]     raddr_next;

  always_comb begin
    if (grid_res == '0) begin
      res_m1 = '0;
    end else if (int'(grid_res) > GRID_MAX) begin
      res_m1 = IDX_W'(GRID_MAX - 1);
    end else begin
      res_m1 = IDX_W'(grid_res - 1'b1);
    end
    ix_next = cell_index($signed(fx_s2[FX_W-1:FRAC_B]), res_m1);
    iz_next = cell_index($signed(fz_s2[FX_W-1:FRAC_B]), res_m1);
    brow_next[0] = IDX_W'(({1'b0, iz_next} + 1'b1) >> 1);
    brow_next[1] = iz_next >> 1;
    bcol_next[0] = IDX_W'(({1'b0, ix_next} + 1'b1) >> 1);
    bcol_next[1] = ix_next >> 1;
    for (int b = 0; b < 4; b++) begin
      raddr_next[b] = bank_addr(brow_next[b/2], bcol_next[b%2]);
    end
  end

  logic                     cmd_s3, wok_s3, px_s3, pz_s3;
  logic [1:0]               wbank_s3;
  logic [BA_W-1:0]          waddr_s3;
  logic signed [HB-1:0]     hval_s3;
  logic [3:0][BA_W-1:0]     raddr_s3;
  logic signed [FX_W-1:0]   tx_s3, tz_s3;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      cmd_s3   <= cmd_s2;
      wok_s3   <= wok_s2;
      wbank_s3 <= wbank_s2;
      waddr_s3 <= waddr_s2;
      hval_s3  <= hval_s2;
      raddr_s3 <= raddr_next;
      px_s3    <= ix_next[0];
      pz_s3    <= iz_next[0];
      tx_s3    <= fx_s2 - FX_W'($signed({1'b0, ix_next, {FRAC_B{1'b0}}}));
      tz_s3    <= fz_s2 - FX_W'($signed({1'b0, iz_next, {FRAC_B{1'b0}}}));
    end
  end

  // stage 4: banked memory, write or four-corner read
  wire [HB-1:0] rd_s4 [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [HB-1:0] mem [BANK_DEPTH];
    logic [HB-1:0] rd;
    always_ff @(posedge clk) begin
      if (rdy[4] && v[3] && cmd_s3 == CMD_WRITE && wok_s3 && wbank_s3 == 2'(b)) begin
        mem[waddr_s3] <= hval_s3;
      end
      if (rdy[4]) begin
        rd <= mem[raddr_s3[b]];
      end
    end
    assign rd_s4[b] = rd;
  end

  logic                     px_s4, pz_s4;
  logic signed [FX_W-1:0]   tx_s4, tz_s4;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      px_s4 <= px_s3;
      pz_s4 <= pz_s3;
      tx_s4 <= tx_s3;
      tz_s4 <= tz_s3;
    end
  end

  // stage 5: corner differences times x fraction
  logic signed [HB-1:0]     h00, h10, h01, h11;
  logic signed [D_W-1:0]    d0, d1;

  always_comb begin
    h00 = $signed(rd_s4[{pz_s4, px_s4}]);
    h10 = $signed(rd_s4[{pz_s4, !px_s4}]);
    h01 = $signed(rd_s4[{!pz_s4, px_s4}]);
    h11 = $signed(rd_s4[{!pz_s4, !px_s4}]);
    d0  = D_W'(h10) - D_W'(h00);
    d1  = D_W'(h11) - D_W'(h01);
  end

  logic signed [HB-1:0]     h00_s5, h01_s5;
  logic signed [PL_W-1:0]   pa_lo_s5, pb_lo_s5;
  logic signed [PH_W-1:0]   pa_hi_s5, pb_hi_s5;
  logic signed [FX_W-1:0]   tz_s5;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      h00_s5   <= h00;
      h01_s5   <= h01;
      pa_lo_s5 <= $signed({1'b0, tx_s4[T_LO-1:0]}) * d0;
      pa_hi_s5 <= $signed(tx_s4[FX_W-1:T_LO]) * d0;
      pb_lo_s5 <= $signed({1'b0, tx_s4[T_LO-1:0]}) * d1;
      pb_hi_s5 <= $signed(tx_s4[FX_W-1:T_LO]) * d1;
      tz_s5    <= tz_s4;
    end
  end

  // stage 6: edge blends a and b
  logic signed [A_W-1:0]    a_s6, b_s6;
  logic signed [FX_W-1:0]   tz_s6;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      a_s6  <= (A_W'(h00_s5) <<< FRAC_B) + A_W'(pa_lo_s5) + (A_W'(pa_hi_s5) <<< T_LO);
      b_s6  <= (A_W'(h01_s5) <<< FRAC_B) + A_W'(pb_lo_s5) + (A_W'(pb_hi_s5) <<< T_LO);
      tz_s6 <= tz_s5;
    end
  end

  // stage 7: b minus a
  logic signed [A_W-1:0]    a_s7;
  logic signed [E_W-1:0]    e_s7;
  logic signed [FX_W-1:0]   tz_s7;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      a_s7  <= a_s6;
      e_s7  <= E_W'(b_s6) - E_W'(a_s6);
      tz_s7 <= tz_s6;
    end
  end

  // stage 8: partial products of z fraction times difference
  logic signed [A_W-1:0]    a_s8;
  logic signed [QLL_W-1:0]  qll_s8;
  logic signed [QLH_W-1:0]  qlh_s8;
  logic signed [QHL_W-1:0]  qhl_s8;
  logic signed [QHH_W-1:0]  qhh_s8;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      a_s8   <= a_s7;
      qll_s8 <= $signed({1'b0, tz_s7[T_LO-1:0]}) * $signed({1'b0, e_s7[E_LO-1:0]});
      qlh_s8 <= $signed({1'b0, tz_s7[T_LO-1:0]}) * $signed(e_s7[E_W-1:E_LO]);
      qhl_s8 <= $signed(tz_s7[FX_W-1:T_LO]) * $signed({1'b0, e_s7[E_LO-1:0]});
      qhh_s8 <= $signed(tz_s7[FX_W-1:T_LO]) * $signed(e_s7[E_W-1:E_LO]);
    end
  end

  // stage 9: pair sums
  logic signed [A_W-1:0]    a_s9;
  logic signed [R_W-1:0]    m1_s9, m2_s9;

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      a_s9  <= a_s8;
      m1_s9 <= R_W'(qll_s8) + (R_W'(qlh_s8) <<< E_LO);
      m2_s9 <= (R_W'(qhl_s8) <<< T_LO) + (R_W'(qhh_s8) <<< (T_LO + E_LO));
    end
  end

  // stage 10: full blend with rounding half
  logic signed [R_W-1:0]    r_s10;

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      r_s10 <= m1_s9 + m2_s9 + (R_W'(a_s9) <<< FRAC_B) + ROUND_HALF;
    end
  end

  // output: round and saturate
  logic signed [Q_W-1:0]    q;
  logic                     sat_hi, sat_lo;

  always_comb begin
    q      = $signed(r_s10[R_W-1:R_SH]);
    sat_hi = q > Q_W'(H_MAX);
    sat_lo = q < Q_W'(H_MIN);
  end

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      priority if (sat_hi) begin
        sampled_height <= H_MAX;
      end else if (sat_lo) begin
        sampled_height <= H_MIN;
      end else begin
        sampled_height <= q[HB-1:0];
      end
      saturated <= sat_hi || sat_lo;
    end
  end

  // advance valid bits; drop write commands after the memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rdy[1])  v[1]      <= in_valid;
      if (rdy[2])  v[2]      <= v[1];
      if (rdy[3])  v[3]      <= v[2];
      if (rdy[4])  v[4]      <= v[3] && cmd_s3 == CMD_SAMPLE;
      if (rdy[5])  v[5]      <= v[4];
      if (rdy[6])  v[6]      <= v[5];
      if (rdy[7])  v[7]      <= v[6];
      if (rdy[8])  v[8]      <= v[7];
      if (rdy[9])  v[9]      <= v[8];
      if (rdy[10]) v[10]     <= v[9];
      if (rdy[11]) out_valid <= v[10];
    end
  end

`ifndef SYNTHESIS
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (v[3] && cmd_s3 == CMD_WRITE && rdy[4]) |=> !v[4])
    else $error("write command entered the blend pipeline");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (sampled_height == H_MAX || sampled_height == H_MIN))
    else $error("saturated result not at a range limit");

  a_read_in_bank: assert property (@(posedge clk) disable iff (rst)
    (v[3] && cmd_s3 == CMD_SAMPLE) |-> (int'(raddr_s3[0]) < BANK_DEPTH))
    else $error("corner read beyond bank depth");

  a_stall_holds_v10: assert property (@(posedge clk) disable iff (rst)
    (v[10] && !rdy[11]) |=> v[10])
    else $error("stage ten lost an item under stall");
`endif

endmodule

// File: sim/heightmap_bilinear_sampler_core_tb.sv
// Self-checking testbench for the heightmap bilinear sampler core.
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_core_tb;
  import hbs_pkg::*;

  localparam int PIPE_LATENCY = 10;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic                    command;
    logic [COORD_W-1:0]      col;
    logic [COORD_W-1:0]      row;
    logic signed [HB-1:0]    height;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] pz;
  } grid_op_t;

  typedef struct packed {
    logic signed [HB-1:0] height;
    logic                 sat;
  } sample_t;

  logic                    clk            = 1'b0;
  logic                    rst            = 1'b1;
  logic                    cfg_valid      = 1'b0;
  logic                    cfg_ready;
  logic [2:0]              cfg_index      = CFG_GRID_RES;
  logic [CFG_W-1:0]        cfg_data       = '0;
  logic                    in_valid       = 1'b0;
  logic                    in_ready;
  logic                    command        = CMD_WRITE;
  logic [COORD_W-1:0]      grid_col       = '0;
  logic [COORD_W-1:0]      grid_row       = '0;
  logic signed [HB-1:0]    height_value   = '0;
  logic signed [POS_W-1:0] pos_x          = '0;
  logic signed [POS_W-1:0] pos_z          = '0;
  logic                    out_valid;
  logic                    out_ready      = 1'b0;
  logic signed [HB-1:0]    sampled_height;
  logic                    saturated;

  logic [RES_W-1:0]        cfg_res     = RES_RST;
  logic [HALF_W-1:0]       cfg_half_w  = HALF_RST;
  logic [HALF_W-1:0]       cfg_half_d  = HALF_RST;
  logic [SCALE_W-1:0]      cfg_scale_x = SCALE_RST;
  logic [SCALE_W-1:0]      cfg_scale_z = SCALE_RST;

  logic signed [HB-1:0] height_store [0:GRID_MAX_DEF][0:GRID_MAX_DEF];
  bit                   written      [0:GRID_MAX_DEF][0:GRID_MAX_DEF];
  sample_t              expected_heights [$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  stall_left     = 0;
  bit  tx_idle_en     = 1'b1;
  bit  rx_stall_en    = 1'b1;

  heightmap_bilinear_sampler_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .grid_col       (grid_col),
    .grid_row       (grid_row),
    .height_value   (height_value),
    .pos_x          (pos_x),
    .pos_z          (pos_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sampled_height (sampled_height),
    .saturated      (saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int grid_cells();
    int res;
    res = int'(cfg_res);
    if (res < 1) res = 1;
    if (res > GRID_MAX_DEF) res = GRID_MAX_DEF;
    return res;
  endfunction

  function automatic longint frac_coord(input logic signed [POS_W-1:0] pos,
                                        input logic [HALF_W-1:0] half,
                                        input logic [SCALE_W-1:0] scale);
    longint p, h, s;
    p = longint'(pos);
    h = longint'(half);
    s = longint'(scale);
    return (p + h) * s;
  endfunction

  function automatic int cell_index(input longint f, input int res);
    longint i;
    i = f >>> FRAC_B;
    if (i > res - 1) i = res - 1;
    if (i < 0) i = 0;
    return int'(i);
  endfunction

  function automatic sample_t blend_sample(input logic signed [POS_W-1:0] px,
                                           input logic signed [POS_W-1:0] pz);
    longint fx, fz, tx, tz;
    int ix, iz, res;
    logic signed [127:0] h00, h10, h01, h11, wtx, wtz, a, b, r;
    sample_t s;
    res = grid_cells();
    fx  = frac_coord(px, cfg_half_w, cfg_scale_x);
    fz  = frac_coord(pz, cfg_half_d, cfg_scale_z);
    ix  = cell_index(fx, res);
    iz  = cell_index(fz, res);
    tx  = fx - (longint'(ix) <<< FRAC_B);
    tz  = fz - (longint'(iz) <<< FRAC_B);
    h00 = 128'(height_store[iz][ix]);
    h10 = 128'(height_store[iz][ix + 1]);
    h01 = 128'(height_store[iz + 1][ix]);
    h11 = 128'(height_store[iz + 1][ix + 1]);
    wtx = 128'(tx);
    wtz = 128'(tz);
    a = (h00 <<< FRAC_B) + wtx * (h10 - h00);
    b = (h01 <<< FRAC_B) + wtx * (h11 - h01);
    r = (a <<< FRAC_B) + wtz * (b - a) + (128'sd1 <<< (R_SH - 1));
    r = r >>> R_SH;
    s.sat = 1'b1;
    if (r > H_MAX) s.height = H_MAX;
    else if (r < H_MIN) s.height = H_MIN;
    else begin
      s.height = r[HB-1:0];
      s.sat    = 1'b0;
    end
    return s;
  endfunction

  function automatic void apply_op(input grid_op_t op);
    if (op.command == CMD_WRITE) begin
      if (op.col <= GRID_MAX_DEF && op.row <= GRID_MAX_DEF) begin
        height_store[op.row][op.col] = op.height;
        written[op.row][op.col]      = 1'b1;
      end
    end else begin
      expected_heights.insert(expected_heights.size(), blend_sample(op.px, op.pz));
    end
  endfunction

  function automatic logic signed [POS_W-1:0] in_span(input logic [HALF_W-1:0] half);
    int v;
    v = -int'(half) + int'($urandom_range(0, 2 * half));
    if (v > 32767) v = 32767;
    return POS_W'(v);
  endfunction

  function automatic grid_op_t random_op();
    grid_op_t op;
    int res, pick;
    res        = grid_cells();
    op.command = ($urandom_range(0, 3) == 0) ? CMD_WRITE : CMD_SAMPLE;
    op.col     = COORD_W'($urandom);
    op.row     = COORD_W'($urandom);
    op.height  = HB'($urandom);
    op.px      = POS_W'($urandom);
    op.pz      = POS_W'($urandom);
    if (op.command == CMD_WRITE) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        op.col = COORD_W'($urandom_range(0, res));
        op.row = COORD_W'($urandom_range(0, res));
      end else if (pick == 8) begin
        op.col = COORD_W'($urandom_range(0, GRID_MAX_DEF));
        op.row = COORD_W'($urandom_range(0, GRID_MAX_DEF));
      end
    end else if ($urandom_range(0, 9) < 7) begin
      op.px = in_span(cfg_half_w);
      op.pz = in_span(cfg_half_d);
    end
    return op;
  endfunction

  function automatic logic [SCALE_W-1:0] scale_for(input int res, input int half);
    longint s;
    s = (longint'(res) <<< 23) / half;
    if (s > {SCALE_W{1'b1}}) s = {SCALE_W{1'b1}};
    return s[SCALE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    sample_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_heights.size() == 0) begin
        report_mismatch("result with nothing pending", longint'(sampled_height), 0);
      end else begin
        want = expected_heights.pop_front();
        if (sampled_height !== want.height)
          report_mismatch("sampled_height", longint'(sampled_height),
                          longint'(want.height));
        if (saturated !== want.sat)
          report_mismatch("saturated", longint'(saturated), longint'(want.sat));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (rx_stall_en) stall_left <= idle_len();
    end
  end

  task automatic send_item(input grid_op_t op);
    int gap;
    in_valid     <= 1'b1;
    command      <= op.command;
    grid_col     <= op.col;
    grid_row     <= op.row;
    height_value <= op.height;
    pos_x        <= op.px;
    pos_z        <= op.pz;
    do @(posedge clk); while (!in_ready);
    apply_op(op);
    gap = tx_idle_en ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_write(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                            input logic signed [HB-1:0] h);
    grid_op_t op;
    op         = random_op();
    op.command = CMD_WRITE;
    op.col     = col;
    op.row     = row;
    op.height  = h;
    send_item(op);
  endtask

  // Fill in any corner of the target cell that has not been written yet.
  task automatic prime_cell(input logic signed [POS_W-1:0] px,
                            input logic signed [POS_W-1:0] pz);
    int ix, iz, res;
    res = grid_cells();
    ix  = cell_index(frac_coord(px, cfg_half_w, cfg_scale_x), res);
    iz  = cell_index(frac_coord(pz, cfg_half_d, cfg_scale_z), res);
    for (int dr = 0; dr < 2; dr++)
      for (int dc = 0; dc < 2; dc++)
        if (!written[iz + dr][ix + dc])
          send_write(COORD_W'(ix + dc), COORD_W'(iz + dr), HB'($urandom));
  endtask

  task automatic send_sample(input logic signed [POS_W-1:0] px,
                             input logic signed [POS_W-1:0] pz);
    grid_op_t op;
    op         = random_op();
    op.command = CMD_SAMPLE;
    op.px      = px;
    op.pz      = pz;
    prime_cell(px, pz);
    send_item(op);
  endtask

  task automatic run_ops(input int n);
    grid_op_t op;
    repeat (n) begin
      op = random_op();
      if (op.command == CMD_SAMPLE) prime_cell(op.px, op.pz);
      send_item(op);
    end
  endtask

  // Drop valid, drain pending results, then let in-flight writes retire.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_heights.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_index_t idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    unique case (idx)
      CFG_GRID_RES:   cfg_res     = data[RES_W-1:0];
      CFG_HALF_WIDTH: cfg_half_w  = data[HALF_W-1:0];
      CFG_HALF_DEPTH: cfg_half_d  = data[HALF_W-1:0];
      CFG_SCALE_X:    cfg_scale_x = data[SCALE_W-1:0];
      CFG_SCALE_Z:    cfg_scale_z = data[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [RES_W-1:0] res, input logic [HALF_W-1:0] hw,
                            input logic [HALF_W-1:0] hd, input logic [SCALE_W-1:0] sx,
                            input logic [SCALE_W-1:0] sz);
    logic [CFG_W-1:0] junk;
    wait_idle();
    junk = CFG_W'($urandom);
    cfg_write(CFG_GRID_RES, {junk[CFG_W-1:RES_W], res});
    junk = CFG_W'($urandom);
    cfg_write(CFG_HALF_WIDTH, {junk[CFG_W-1:HALF_W], hw});
    junk = CFG_W'($urandom);
    cfg_write(CFG_HALF_DEPTH, {junk[CFG_W-1:HALF_W], hd});
    cfg_write(CFG_SCALE_X, sx);
    cfg_write(CFG_SCALE_Z, sz);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_corners();
    send_write(0, 0, H_MAX);
    send_write(1, 0, H_MIN);
    send_write(0, 1, H_MIN);
    send_write(1, 1, H_MAX);
    send_write(33, 0, 16'sd1234);
    send_write(0, 63, -16'sd999);
    send_write(63, 63, H_MIN);
    send_sample(-5120, -5120);
    send_sample(-4800, -4960);
    send_sample(-5121, -5120);
    send_sample(-32768, -5120);
    send_sample(-32768, -32768);
    send_sample(32767, 32767);
    send_sample(0, 0);
  endtask

  task automatic test_resolution_extremes();
    set_config(1, 1, 1, scale_for(1, 1), scale_for(1, 1));
    run_ops(25);
    set_config(RES_W'(GRID_MAX_DEF), {HALF_W{1'b1}}, {HALF_W{1'b1}},
               scale_for(GRID_MAX_DEF, 32767), scale_for(GRID_MAX_DEF, 32767));
    run_ops(25);
    set_config(0, 0, 0, 0, 0);
    run_ops(20);
    set_config({RES_W{1'b1}}, HALF_W'($urandom_range(1, 32767)),
               HALF_W'($urandom_range(1, 32767)), {SCALE_W{1'b1}}, {SCALE_W{1'b1}});
    run_ops(25);
  endtask

  task automatic test_random_configs();
    int res, hw, hd;
    repeat (5) begin
      res = $urandom_range(1, GRID_MAX_DEF);
      hw  = $urandom_range(1, 32767);
      hd  = $urandom_range(1, 32767);
      set_config(RES_W'(res), HALF_W'(hw), HALF_W'(hd),
                 scale_for(res, hw), scale_for(res, hd));
      run_ops(40);
    end
  endtask

  task automatic test_drain_pause();
    set_config(RES_RST, HALF_RST, HALF_RST, SCALE_RST, SCALE_RST);
    run_ops(30);
    wait_idle();
    run_ops(30);
  endtask

  task automatic test_back_to_back();
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    run_ops(40);
    rx_stall_en = 1'b1;
    run_ops(30);
    tx_idle_en  = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_resolution_extremes();
    test_random_configs();
    test_drain_pause();
    test_back_to_back();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/hbs_pkg.sv
rtl/core/heightmap_bilinear_sampler_core.sv
sim/heightmap_bilinear_sampler_core_tb.sv
